[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the sorted set design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define SUS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, at every rising clock edge outside of reset.
`define SUS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sus_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted set package
// Request, response, control types and status codes of the sorted set.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 6;
  localparam int unsigned CntW = 7;
  localparam logic [ValW-1:0] ReservedValue = 32'h8000_0000;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_READ   = 1'b1
  } req_kind_t;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_READ_BAD  = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic                   req_type;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        position;
  } in_req_t;

  typedef struct packed {
    logic [2:0]             status;
    logic signed [ValW-1:0] read_value;
    logic [CntW-1:0]        count;
  } out_rsp_t;

  typedef struct packed {
    logic                   shift_en;
    logic signed [ValW-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/sorted_unique_set_insert.sv]
// ----------------------------------------------------------------------------
// Sorted unique set
// Keeps distinct signed values in ascending order in a row of cells.
//
//   Channel | Ports                        | Moves
//   in      | in_valid, in_stall, in_req   | insert or read request
//   out     | out_valid, out_stall, out_rsp| status, read value, count
//
// A request is accepted in ST_IDLE, then all cells compare in ST_EXEC and
// shift in parallel. The next request is accepted once the response has
// moved into the output register and that register is free or being taken.
// Reset clears the element count and control state; cell contents are kept.
// A stalled output holds its response and blocks new requests.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_insert #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sus_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sus_pkg::out_rsp_t      out_rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RdN = (DEPTH < 64) ? DEPTH : 64;

  sus_pkg::state_t   state_r, state_nxt;
  sus_pkg::in_req_t  req_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  sus_pkg::out_rsp_t rsp_r, rsp_nxt;

  logic                             accept;
  logic                             exec;
  logic                             dup;
  logic                             full;
  logic                             commit;
  logic                             rd_ok;
  logic signed [sus_pkg::ValW-1:0]  rd_val;
  sus_pkg::cell_ctl_t               ctl;

  logic [DEPTH-1:0]                 occ;
  logic [DEPTH-1:0]                 lt_w;
  logic [DEPTH-1:0]                 eq_w;
  logic signed [sus_pkg::ValW-1:0]  val_w [DEPTH];

  assign accept    = in_valid && !in_stall;
  assign exec      = (state_r == sus_pkg::ST_EXEC);
  assign in_stall  = (state_r != sus_pkg::ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  assign full   = (count_r == CW'(DEPTH));
  assign dup    = (req_r.value == sus_pkg::ReservedValue) || (|eq_w);
  assign commit = exec && (req_r.req_type == sus_pkg::REQ_INSERT) && !dup && !full;
  assign rd_ok  = (32'(req_r.position) < 32'(count_r));

  assign ctl.shift_en = commit;
  assign ctl.value    = req_r.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (32'(i) < 32'(count_r));
    if (i == 0) begin : g_first
      sus_cell u_node (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ[i]),
        .left_lt  (1'b1),
        .left_val (req_r.value),
        .lt       (lt_w[i]),
        .eq       (eq_w[i]),
        .val      (val_w[i])
      );
    end else begin : g_rest
      sus_cell u_node (
        .clk      (clk),
        .ctl      (ctl),
        .occ      (occ[i]),
        .left_lt  (lt_w[i-1]),
        .left_val (val_w[i-1]),
        .lt       (lt_w[i]),
        .eq       (eq_w[i]),
        .val      (val_w[i])
      );
    end
  end

  always_comb begin
    rd_val = '0;
    for (int i = 0; i < RdN; i++) begin
      if (occ[i] && (req_r.position == sus_pkg::PosW'(i))) begin
        rd_val = rd_val | val_w[i];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sus_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sus_pkg::ST_EXEC;
        end
      end
      sus_pkg::ST_EXEC: begin
        state_nxt = sus_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sus_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt     = commit ? count_r + CW'(1) : count_r;
    out_valid_nxt = exec || (out_valid_r && out_stall);
    rsp_nxt       = rsp_r;
    if (exec) begin
      rsp_nxt.read_value = '0;
      rsp_nxt.count      = sus_pkg::CntW'(count_nxt);
      if (req_r.req_type == sus_pkg::REQ_READ) begin
        if (rd_ok) begin
          rsp_nxt.status     = sus_pkg::STAT_READ_OK;
          rsp_nxt.read_value = rd_val;
        end else begin
          rsp_nxt.status = sus_pkg::STAT_READ_BAD;
        end
      end else if (dup) begin
        rsp_nxt.status = sus_pkg::STAT_DUPLICATE;
      end else if (full) begin
        rsp_nxt.status = sus_pkg::STAT_FULL;
      end else begin
        rsp_nxt.status = sus_pkg::STAT_INSERTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sus_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    rsp_r <= rsp_nxt;
  end

`include "assert_macros.svh"

  `SUS_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "element count above depth")
  `SUS_ASSERT_NEXT(a_accept_exec, accept, state_r == sus_pkg::ST_EXEC, "accept without execute")
  `SUS_ASSERT_NEXT(a_commit_count, commit, count_r == $past(count_r) + CW'(1), "count not advanced")
  `SUS_ASSERT(a_exec_out_free, !(exec && out_valid_r), "execute with output occupied")

endmodule

`default_nettype wire

[sv/sus_cell.sv]
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one element, compares it with the request value and shifts up.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cell (
  input  wire logic                         clk,
  input  wire sus_pkg::cell_ctl_t           ctl,
  input  wire logic                         occ,
  input  wire logic                         left_lt,
  input  wire logic signed [sus_pkg::ValW-1:0] left_val,
  output logic                              lt,
  output logic                              eq,
  output logic signed [sus_pkg::ValW-1:0]   val
);

  logic signed [sus_pkg::ValW-1:0] val_r;
  logic signed [sus_pkg::ValW-1:0] val_nxt;

  assign val = val_r;
  assign lt  = occ && (val_r < ctl.value);
  assign eq  = occ && (val_r == ctl.value);

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift_en && !lt) begin
      val_nxt = left_lt ? ctl.value : left_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire
